### design/rtdd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rtdd_pkg;
    localparam int RES_SLOTS = 3;
    localparam logic [7:0] INIT_UNITS = 8'd9;

    localparam logic [1:0] CMD_CREATE = 2'd0;
    localparam logic [1:0] CMD_TERM   = 2'd1;
    localparam logic [1:0] CMD_DETECT = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [2:0] ST_GRANTED  = 3'd0;
    localparam logic [2:0] ST_PENDING  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_TERM     = 3'd3;
    localparam logic [2:0] ST_UNKNOWN  = 3'd4;
    localparam logic [2:0] ST_NO_DEAD  = 3'd5;
    localparam logic [2:0] ST_DEAD     = 3'd6;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] client_tag;
        logic [7:0]  want_0;
        logic [7:0]  want_1;
        logic [7:0]  want_2;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] stuck_tag;
        logic [7:0]  free_0;
        logic [7:0]  free_1;
        logic [7:0]  free_2;
    } out_item_t;

    // One client entry as kept in the table memory.
    typedef struct packed {
        logic [15:0] tag;
        logic [23:0] held;
        logic [23:0] pend;
    } entry_t;
endpackage
`default_nettype wire

### design/resource_table_deadlock_detector_unit.sv
// Create appends one entry; terminate searches for the tag, then shifts later entries
// down through the table memory. Detect makes repeated passes over the table, reading
// each entry and checking it when its data arrives, until a pass makes no progress.
// One item at a time; the result register frees the input once it is taken.
// Reset (aresetn low, synchronous) empties the table and loads free units with 9.
`timescale 1ns / 1ps
`default_nettype none
module resource_table_deadlock_detector_unit #(
    parameter int MAX_CLIENTS   = 16,
    parameter int NUM_RESOURCES = 3
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        s_valid,
    output logic                       s_ready,
    input  rtdd_pkg::in_item_t         s_data,
    output logic                       m_valid,
    input  wire                        m_ready,
    output rtdd_pkg::out_item_t        m_data,
    input  wire                        cfg_we,
    input  wire [1:0]                  cfg_index,
    input  wire [7:0]                  cfg_data
);
    localparam int IW = $clog2(MAX_CLIENTS);
    localparam int CW = $clog2(MAX_CLIENTS + 1);
    localparam int WW = $clog2(256 * (MAX_CLIENTS + 1));
    localparam int RES_SLOTS_L = rtdd_pkg::RES_SLOTS;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FIND   = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_DET    = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_CREATE = 3'd5;

    logic [2:0]  state_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic [7:0]  free_reg [RES_SLOTS_L];
    logic [WW-1:0] work_reg [RES_SLOTS_L];
    logic [MAX_CLIENTS-1:0] done_reg;
    logic        prog_reg;
    logic        rd_pend_reg;
    rtdd_pkg::in_item_t item_reg;
    rtdd_pkg::out_item_t out_reg;
    logic        out_valid_reg;

    // Table memory: one write port, one registered read port.
    rtdd_pkg::entry_t mem [MAX_CLIENTS];
    rtdd_pkg::entry_t rd_q;
    logic [IW-1:0]    rd_addr;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    rtdd_pkg::entry_t wr_data;

    // The shift reads the entry above the one being filled; all other scans read idx.
    assign rd_addr = (state_reg == S_SHIFT) ? IW'(idx_reg + 1'b1) : idx_reg[IW-1:0];

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_q <= mem[rd_addr];
    end

    assign s_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    function automatic logic [7:0] want_of(input rtdd_pkg::in_item_t it, input int k);
        logic [7:0] w;
        w = (k == 0) ? it.want_0 : (k == 1) ? it.want_1 : it.want_2;
        return (k < NUM_RESOURCES) ? w : 8'd0;
    endfunction

    logic [7:0] fv [RES_SLOTS_L];
    logic fits;
    logic ok;
    logic [23:0] wants;
    assign wants = {want_of(item_reg, 0), want_of(item_reg, 1), want_of(item_reg, 2)};

    always_comb begin
        fits = 1'b1;
        ok = 1'b1;
        for (int k = 0; k < RES_SLOTS_L; k++) begin
            if (want_of(item_reg, k) > free_reg[k]) fits = 1'b0;
            if (k < NUM_RESOURCES &&
                {{(WW-8){1'b0}}, rd_q.pend[23-8*k -: 8]} > work_reg[k]) ok = 1'b0;
            fv[k] = (k < NUM_RESOURCES) ? free_reg[k] : 8'd0;
        end
    end

    // Table writes: append on create, move an entry down during the shift.
    always_comb begin
        wr_en = 1'b0;
        wr_addr = idx_reg[IW-1:0];
        wr_data = rd_q;
        if (aresetn && state_reg == S_CREATE && count_reg < CW'(MAX_CLIENTS)) begin
            wr_en = 1'b1;
            wr_addr = count_reg[IW-1:0];
            wr_data.tag = item_reg.client_tag;
            wr_data.held = fits ? wants : 24'd0;
            wr_data.pend = fits ? 24'd0 : wants;
        end else if (aresetn && state_reg == S_SHIFT && rd_pend_reg) begin
            wr_en = 1'b1;
        end
    end

    // Main sequencer.
    always_ff @(posedge aclk) begin
        logic [8:0] s;
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            for (int k = 0; k < RES_SLOTS_L; k++) begin
                free_reg[k] <= (k < NUM_RESOURCES) ? rtdd_pkg::INIT_UNITS : 8'd0;
            end
        end else begin
            if (m_valid && m_ready) out_valid_reg <= 1'b0;
            if (cfg_we && cfg_index < 2'(RES_SLOTS_L)) begin
                if (int'(cfg_index) < NUM_RESOURCES) free_reg[cfg_index] <= cfg_data;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        item_reg <= s_data;
                        idx_reg <= '0;
                        rd_pend_reg <= 1'b0;
                        case (s_data.cmd)
                            rtdd_pkg::CMD_CREATE: state_reg <= S_CREATE;
                            rtdd_pkg::CMD_TERM:   state_reg <= S_FIND;
                            rtdd_pkg::CMD_DETECT: begin
                                state_reg <= S_DET;
                                done_reg <= '0;
                                prog_reg <= 1'b0;
                                for (int k = 0; k < RES_SLOTS_L; k++)
                                    work_reg[k] <= {{(WW-8){1'b0}}, free_reg[k]};
                            end
                            default: begin
                                out_reg <= '{rtdd_pkg::ST_UNKNOWN, 16'd0, fv[0], fv[1], fv[2]};
                                out_valid_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_CREATE: begin
                    // Create: append or report full.
                    if (count_reg >= CW'(MAX_CLIENTS)) begin
                        out_reg <= '{rtdd_pkg::ST_FULL, 16'd0, fv[0], fv[1], fv[2]};
                    end else begin
                        count_reg <= count_reg + 1'b1;
                        for (int k = 0; k < RES_SLOTS_L; k++)
                            if (fits) free_reg[k] <= free_reg[k] - want_of(item_reg, k);
                        out_reg <= '{fits ? rtdd_pkg::ST_GRANTED : rtdd_pkg::ST_PENDING,
                                     16'd0, fv[0] - (fits ? want_of(item_reg,0) : 8'd0),
                                     fv[1] - (fits ? want_of(item_reg,1) : 8'd0),
                                     fv[2] - (fits ? want_of(item_reg,2) : 8'd0)};
                    end
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_FIND: begin
                    // Read one entry; compare when the data arrives the next cycle.
                    if (rd_pend_reg) begin
                        rd_pend_reg <= 1'b0;
                        if (rd_q.tag == item_reg.client_tag) begin
                            for (int k = 0; k < RES_SLOTS_L; k++)
                                if (k < NUM_RESOURCES) begin
                                    s = {1'b0, free_reg[k]} + {1'b0, rd_q.held[23-8*k -: 8]};
                                    free_reg[k] <= s[8] ? 8'hFF : s[7:0];
                                end
                            state_reg <= S_SHIFT;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end else if (idx_reg >= count_reg) begin
                        out_reg <= '{rtdd_pkg::ST_UNKNOWN, 16'd0, fv[0], fv[1], fv[2]};
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end else begin
                        rd_pend_reg <= 1'b1;
                    end
                end
                S_SHIFT: begin
                    // Move entry idx+1 down to idx: read it, then write it when the data arrives.
                    if (rd_pend_reg) begin
                        rd_pend_reg <= 1'b0;
                        idx_reg <= idx_reg + 1'b1;
                    end else if (idx_reg + 1'b1 >= count_reg) begin
                        count_reg <= count_reg - 1'b1;
                        out_reg <= '{rtdd_pkg::ST_TERM, 16'd0, fv[0], fv[1], fv[2]};
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end else begin
                        rd_pend_reg <= 1'b1;
                    end
                end
                S_DET: begin
                    // Passes over the table until one makes no progress; an entry read gets checked next cycle.
                    if (rd_pend_reg) begin
                        rd_pend_reg <= 1'b0;
                        if (!done_reg[idx_reg[IW-1:0]] && ok) begin
                            done_reg[idx_reg[IW-1:0]] <= 1'b1;
                            prog_reg <= 1'b1;
                            for (int k = 0; k < RES_SLOTS_L; k++)
                                if (k < NUM_RESOURCES)
                                    work_reg[k] <= work_reg[k] +
                                                   {{(WW-8){1'b0}}, rd_q.held[23-8*k -: 8]};
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end else if (idx_reg >= count_reg) begin
                        idx_reg <= '0;
                        prog_reg <= 1'b0;
                        if (!prog_reg) state_reg <= S_SCAN;
                    end else begin
                        rd_pend_reg <= 1'b1;
                    end
                end
                S_SCAN: begin
                    // Find the first unfinished entry and fetch its tag.
                    if (rd_pend_reg) begin
                        rd_pend_reg <= 1'b0;
                        out_reg <= '{rtdd_pkg::ST_DEAD, rd_q.tag, fv[0], fv[1], fv[2]};
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end else if (idx_reg >= count_reg) begin
                        out_reg <= '{rtdd_pkg::ST_NO_DEAD, 16'd0, fv[0], fv[1], fv[2]};
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end else if (!done_reg[idx_reg[IW-1:0]]) begin
                        rd_pend_reg <= 1'b1;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Work sums reach at most 255 free units plus 255 held by every entry, which
    // the work width covers without wrapping.
endmodule
`default_nettype wire

### design/rtdd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module rtdd_checker (
    input wire aclk,
    input wire aresetn,
    input wire s_valid,
    input wire s_ready,
    input wire m_valid,
    input wire m_ready,
    input wire [2:0] m_status
);
    // A result stays until taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    // Status codes above the deadlock code never appear.
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= rtdd_pkg::ST_DEAD) else $error("bad status");
    // No new item is taken while a result waits.
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("overlap");
endmodule

bind resource_table_deadlock_detector_unit rtdd_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_data.status)
);
`default_nettype wire
